### hw/rtl/next_permutation_generator_assert.svh
`ifndef NEXT_PERMUTATION_GENERATOR_ASSERT_SVH
`define NEXT_PERMUTATION_GENERATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define NPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define NPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/npg_pkg.sv
`timescale 1ns / 1ps

package npg_pkg;

    localparam int MAX_LEN = 64;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int VAL_W   = 16;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
    } t_in_item;

    typedef struct packed {
        logic [VAL_W-1:0] value_res;
        logic             last_res;
        logic             wrapped;
    } t_out_item;

    typedef enum logic [4:0] {
        UP_LOAD,
        UP_SCAN_INIT,
        UP_SCAN_RD0,
        UP_SCAN_TOP,
        UP_SCAN_RD,
        UP_SCAN_CMP,
        UP_SCAN_NEXT,
        UP_FOUND,
        UP_SUCC_RD,
        UP_SUCC_CMP,
        UP_SUCC_NEXT,
        UP_SWAP_J,
        UP_SWAP_I,
        UP_NOPIV,
        UP_REV_TEST,
        UP_REV_RDI,
        UP_REV_RDJ,
        UP_REV_WRI,
        UP_REV_WRJ,
        UP_EMIT_INIT,
        UP_EMIT_RD,
        UP_EMIT_WAIT,
        UP_EMIT_PUT,
        UP_DONE
    } t_upc;

    typedef enum logic [0:0] {RA_I, RA_J} t_ra_sel;
    typedef enum logic [1:0] {WA_CNT, WA_I, WA_J} t_wa_sel;
    typedef enum logic [1:0] {WD_IN, WD_A, WD_RD} t_wd_sel;
    typedef enum logic [2:0] {IOP_HOLD, IOP_NM1, IOP_DEC, IOP_INC, IOP_ZERO} t_iop;
    typedef enum logic [1:0] {JOP_HOLD, JOP_NM1, JOP_DEC} t_jop;
    typedef enum logic [1:0] {WRP_HOLD, WRP_CLR, WRP_SET} t_wrap_op;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN_LAST,
        C_I_ZERO,
        C_RD_LT_A,
        C_RD_GT_A,
        C_I_LT_J,
        C_OUT_FREE,
        C_I_LAST
    } t_cond;

    typedef struct packed {
        logic     accept;
        logic     rd_en;
        t_ra_sel  ra_sel;
        logic     we;
        t_wa_sel  wa_sel;
        t_wd_sel  wd_sel;
        t_iop     i_op;
        t_jop     j_op;
        logic     a_ld;
        t_wrap_op wrap_op;
        logic     ld_out;
        logic     clr_cnt;
        t_cond    cond;
        t_upc     jt;
        t_upc     jf;
    } t_cword;

    typedef struct packed {
        logic in_last;
        logic i_zero;
        logic rd_lt_a;
        logic rd_gt_a;
        logic i_lt_j;
        logic out_free;
        logic i_last;
    } t_flags;

endpackage

### hw/rtl/next_permutation_generator.sv
`timescale 1ns / 1ps

// channel | handshake           | payload                         | item
// --------+---------------------+---------------------------------+---------------------
// input   | i_valid / o_stall   | i_item  (value, last)           | one sequence element
// output  | o_valid / i_stall   | o_item  (value_res, last_res,   | one result element
//         |                     |          wrapped)               |
//
// Loading accepts one element per cycle. After the final element the sequencer
// scans for the pivot; if one exists it searches the successor and swaps the two,
// else the result wraps. It then reverses the suffix and emits the results, holding
// while the output register is full; one registered memory read paces each step.
// Input stall is high after the final element is taken until UP_DONE ends.
// Reset (synchronous, active low) returns to loading with an empty sequence.

`include "next_permutation_generator_assert.svh"

module next_permutation_generator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  npg_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output npg_pkg::t_out_item  o_item
);
    import npg_pkg::*;

    t_upc   r_pc;
    t_upc   n_pc;
    t_cword cw;
    t_flags flags;
    logic   cond_hit;

    npg_rom u_rom (
        .i_pc (r_pc),
        .o_cw (cw)
    );

    npg_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cw    (cw),
        .i_valid (i_valid),
        .i_item  (i_item),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_item  (o_item),
        .o_flags (flags)
    );

    always_comb begin
        case (cw.cond)
            C_ALWAYS:   cond_hit = 1'b1;
            C_IN_LAST:  cond_hit = flags.in_last;
            C_I_ZERO:   cond_hit = flags.i_zero;
            C_RD_LT_A:  cond_hit = flags.rd_lt_a;
            C_RD_GT_A:  cond_hit = flags.rd_gt_a;
            C_I_LT_J:   cond_hit = flags.i_lt_j;
            C_OUT_FREE: cond_hit = flags.out_free;
            C_I_LAST:   cond_hit = flags.i_last;
            default:    cond_hit = 1'b1;
        endcase
        n_pc = cond_hit ? cw.jt : cw.jf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= UP_LOAD;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_stall = !cw.accept;

    `NPG_ASSERT_NXT(a_last_starts_scan, i_clk, i_rst_n,
        i_valid && !o_stall && i_item.last, r_pc == UP_SCAN_INIT,
        "final item did not start scan")
    `NPG_ASSERT_IMP(a_load_when_free, i_clk, i_rst_n,
        cw.ld_out, flags.out_free, "output register overwritten")
    `NPG_ASSERT_NXT(a_load_shows_valid, i_clk, i_rst_n,
        cw.ld_out, o_valid, "loaded result not presented")

endmodule

### hw/rtl/npg_rom.sv
`timescale 1ns / 1ps

module npg_rom (
    input  npg_pkg::t_upc   i_pc,
    output npg_pkg::t_cword o_cw
);
    import npg_pkg::*;

    always_comb begin
        o_cw = '0;
        case (i_pc)
            UP_LOAD: begin
                o_cw.accept = 1'b1;
                o_cw.we     = 1'b1;
                o_cw.wa_sel = WA_CNT;
                o_cw.wd_sel = WD_IN;
                o_cw.cond   = C_IN_LAST;
                o_cw.jt     = UP_SCAN_INIT;
                o_cw.jf     = UP_LOAD;
            end
            UP_SCAN_INIT: begin
                o_cw.i_op    = IOP_NM1;
                o_cw.wrap_op = WRP_CLR;
                o_cw.cond    = C_ALWAYS;
                o_cw.jt      = UP_SCAN_RD0;
            end
            UP_SCAN_RD0: begin
                o_cw.rd_en  = 1'b1;
                o_cw.ra_sel = RA_I;
                o_cw.cond   = C_ALWAYS;
                o_cw.jt     = UP_SCAN_TOP;
            end
            UP_SCAN_TOP: begin
                o_cw.a_ld = 1'b1;
                o_cw.i_op = IOP_DEC;
                o_cw.cond = C_I_ZERO;
                o_cw.jt   = UP_NOPIV;
                o_cw.jf   = UP_SCAN_RD;
            end
            UP_SCAN_RD: begin
                o_cw.rd_en  = 1'b1;
                o_cw.ra_sel = RA_I;
                o_cw.cond   = C_ALWAYS;
                o_cw.jt     = UP_SCAN_CMP;
            end
            UP_SCAN_CMP: begin
                o_cw.cond = C_RD_LT_A;
                o_cw.jt   = UP_FOUND;
                o_cw.jf   = UP_SCAN_NEXT;
            end
            UP_SCAN_NEXT: begin
                o_cw.a_ld = 1'b1;
                o_cw.i_op = IOP_DEC;
                o_cw.cond = C_I_ZERO;
                o_cw.jt   = UP_NOPIV;
                o_cw.jf   = UP_SCAN_RD;
            end
            UP_FOUND: begin
                o_cw.a_ld = 1'b1;
                o_cw.j_op = JOP_NM1;
                o_cw.cond = C_ALWAYS;
                o_cw.jt   = UP_SUCC_RD;
            end
            UP_SUCC_RD: begin
                o_cw.rd_en  = 1'b1;
                o_cw.ra_sel = RA_J;
                o_cw.cond   = C_ALWAYS;
                o_cw.jt     = UP_SUCC_CMP;
            end
            UP_SUCC_CMP: begin
                o_cw.cond = C_RD_GT_A;
                o_cw.jt   = UP_SWAP_J;
                o_cw.jf   = UP_SUCC_NEXT;
            end
            UP_SUCC_NEXT: begin
                o_cw.j_op = JOP_DEC;
                o_cw.cond = C_ALWAYS;
                o_cw.jt   = UP_SUCC_RD;
            end
            UP_SWAP_J: begin
                o_cw.we     = 1'b1;
                o_cw.wa_sel = WA_J;
                o_cw.wd_sel = WD_A;
                o_cw.cond   = C_ALWAYS;
                o_cw.jt     = UP_SWAP_I;
            end
            UP_SWAP_I: begin
                o_cw.we     = 1'b1;
                o_cw.wa_sel = WA_I;
                o_cw.wd_sel = WD_RD;
                o_cw.i_op   = IOP_INC;
                o_cw.j_op   = JOP_NM1;
                o_cw.cond   = C_ALWAYS;
                o_cw.jt     = UP_REV_TEST;
            end
            UP_NOPIV: begin
                o_cw.wrap_op = WRP_SET;
                o_cw.i_op    = IOP_ZERO;
                o_cw.j_op    = JOP_NM1;
                o_cw.cond    = C_ALWAYS;
                o_cw.jt      = UP_REV_TEST;
            end
            UP_REV_TEST: begin
                o_cw.cond = C_I_LT_J;
                o_cw.jt   = UP_REV_RDI;
                o_cw.jf   = UP_EMIT_INIT;
            end
            UP_REV_RDI: begin
                o_cw.rd_en  = 1'b1;
                o_cw.ra_sel = RA_I;
                o_cw.cond   = C_ALWAYS;
                o_cw.jt     = UP_REV_RDJ;
            end
            UP_REV_RDJ: begin
                o_cw.a_ld   = 1'b1;
                o_cw.rd_en  = 1'b1;
                o_cw.ra_sel = RA_J;
                o_cw.cond   = C_ALWAYS;
                o_cw.jt     = UP_REV_WRI;
            end
            UP_REV_WRI: begin
                o_cw.we     = 1'b1;
                o_cw.wa_sel = WA_I;
                o_cw.wd_sel = WD_RD;
                o_cw.cond   = C_ALWAYS;
                o_cw.jt     = UP_REV_WRJ;
            end
            UP_REV_WRJ: begin
                o_cw.we     = 1'b1;
                o_cw.wa_sel = WA_J;
                o_cw.wd_sel = WD_A;
                o_cw.i_op   = IOP_INC;
                o_cw.j_op   = JOP_DEC;
                o_cw.cond   = C_ALWAYS;
                o_cw.jt     = UP_REV_TEST;
            end
            UP_EMIT_INIT: begin
                o_cw.i_op = IOP_ZERO;
                o_cw.cond = C_ALWAYS;
                o_cw.jt   = UP_EMIT_RD;
            end
            UP_EMIT_RD: begin
                o_cw.rd_en  = 1'b1;
                o_cw.ra_sel = RA_I;
                o_cw.cond   = C_ALWAYS;
                o_cw.jt     = UP_EMIT_WAIT;
            end
            UP_EMIT_WAIT: begin
                o_cw.cond = C_OUT_FREE;
                o_cw.jt   = UP_EMIT_PUT;
                o_cw.jf   = UP_EMIT_WAIT;
            end
            UP_EMIT_PUT: begin
                o_cw.ld_out = 1'b1;
                o_cw.i_op   = IOP_INC;
                o_cw.cond   = C_I_LAST;
                o_cw.jt     = UP_DONE;
                o_cw.jf     = UP_EMIT_RD;
            end
            UP_DONE: begin
                o_cw.clr_cnt = 1'b1;
                o_cw.cond    = C_ALWAYS;
                o_cw.jt      = UP_LOAD;
            end
            default: begin
                o_cw.cond = C_ALWAYS;
                o_cw.jt   = UP_LOAD;
            end
        endcase
    end

endmodule

### hw/rtl/npg_ram.sv
`timescale 1ns / 1ps

module npg_ram (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [npg_pkg::ADDR_W-1:0]   i_waddr,
    input  logic [npg_pkg::VAL_W-1:0]    i_wdata,
    input  logic                         i_re,
    input  logic [npg_pkg::ADDR_W-1:0]   i_raddr,
    output logic [npg_pkg::VAL_W-1:0]    o_rdata
);
    import npg_pkg::*;

    logic [VAL_W-1:0] r_mem [MAX_LEN];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/npg_datapath.sv
`timescale 1ns / 1ps

module npg_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  npg_pkg::t_cword     i_cw,
    input  logic                i_valid,
    input  npg_pkg::t_in_item   i_item,
    input  logic                i_stall,
    output logic                o_valid,
    output npg_pkg::t_out_item  o_item,
    output npg_pkg::t_flags     o_flags
);
    import npg_pkg::*;

    logic [CNT_W-1:0]  r_cnt;
    logic [ADDR_W-1:0] r_i;
    logic [ADDR_W-1:0] r_j;
    logic [VAL_W-1:0]  r_a;
    logic              r_wrap;
    logic              r_ovalid;
    t_out_item         r_oitem;

    logic [ADDR_W-1:0] nm1;
    logic [VAL_W-1:0]  rdata;
    logic              in_acc;
    logic              cnt_room;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
    logic              out_free;

    assign nm1      = ADDR_W'(r_cnt - CNT_W'(1));
    assign in_acc   = i_cw.accept && i_valid;
    assign cnt_room = (r_cnt < CNT_W'(MAX_LEN));
    assign out_free = !r_ovalid || !i_stall;

    always_comb begin
        case (i_cw.wa_sel)
            WA_CNT:  waddr = r_cnt[ADDR_W-1:0];
            WA_I:    waddr = r_i;
            WA_J:    waddr = r_j;
            default: waddr = r_i;
        endcase
        case (i_cw.wd_sel)
            WD_IN:   wdata = i_item.value;
            WD_A:    wdata = r_a;
            WD_RD:   wdata = rdata;
            default: wdata = rdata;
        endcase
        if (i_cw.wa_sel == WA_CNT) begin
            we = i_cw.we && in_acc && cnt_room;
        end else begin
            we = i_cw.we;
        end
        raddr = (i_cw.ra_sel == RA_J) ? r_j : r_i;
    end

    npg_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cw.rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cw.clr_cnt) begin
                r_cnt <= '0;
            end else if (in_acc && cnt_room) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (i_cw.ld_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cw.i_op)
            IOP_NM1:  r_i <= nm1;
            IOP_DEC:  r_i <= r_i - ADDR_W'(1);
            IOP_INC:  r_i <= r_i + ADDR_W'(1);
            IOP_ZERO: r_i <= '0;
            default:  r_i <= r_i;
        endcase
        case (i_cw.j_op)
            JOP_NM1: r_j <= nm1;
            JOP_DEC: r_j <= r_j - ADDR_W'(1);
            default: r_j <= r_j;
        endcase
        case (i_cw.wrap_op)
            WRP_CLR: r_wrap <= 1'b0;
            WRP_SET: r_wrap <= 1'b1;
            default: r_wrap <= r_wrap;
        endcase
        if (i_cw.a_ld) begin
            r_a <= rdata;
        end
        if (i_cw.ld_out) begin
            r_oitem.value_res <= rdata;
            r_oitem.last_res  <= (r_i == nm1);
            r_oitem.wrapped   <= r_wrap;
        end
    end

    assign o_valid = r_ovalid;
    assign o_item  = r_oitem;

    assign o_flags.in_last  = in_acc && i_item.last;
    assign o_flags.i_zero   = (r_i == '0);
    assign o_flags.rd_lt_a  = (rdata < r_a);
    assign o_flags.rd_gt_a  = (rdata > r_a);
    assign o_flags.i_lt_j   = (r_i < r_j);
    assign o_flags.out_free = out_free;
    assign o_flags.i_last   = (r_i == nm1);

endmodule

### test/next_permutation_generator_tb.sv
`timescale 1ns / 1ps

module next_permutation_generator_tb;

    import npg_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int ITEM_TARGET  = 330;
    localparam int DRAIN_CYCLES = 60;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_item;

    next_permutation_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    // predictor state
    logic [VAL_W-1:0] seq_store [MAX_LEN];
    int               seq_len;
    t_out_item        succ_q [$];

    logic [VAL_W-1:0] seq_buf [$];
    int               error_count;
    int               sent_items;
    int               burst_left;
    int               cycle_count;
    int               stall_cycle;
    int               stall_left;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL next_permutation_generator");
            $finish;
        end
    end

    // successor of the held sequence, queued as expected result items
    function automatic void queue_successor();
        int               n;
        int               p;
        int               j;
        int               lo;
        int               hi;
        logic             found;
        logic             wrap;
        logic [VAL_W-1:0] tmp;
        t_out_item        res;
        n = seq_len;
        found = 1'b0;
        p = 0;
        if (n >= 2) begin
            for (p = n - 1; p > 0; p--) begin
                if (seq_store[p-1] < seq_store[p]) begin
                    found = 1'b1;
                    break;
                end
            end
        end
        wrap = !found;
        if (found) begin
            p = p - 1;
            j = n - 1;
            while (j > p && seq_store[j] <= seq_store[p]) j--;
            tmp = seq_store[p];
            seq_store[p] = seq_store[j];
            seq_store[j] = tmp;
            lo = p + 1;
        end else begin
            lo = 0;
        end
        hi = n - 1;
        while (lo < hi) begin
            tmp = seq_store[lo];
            seq_store[lo] = seq_store[hi];
            seq_store[hi] = tmp;
            lo++;
            hi--;
        end
        for (int k = 0; k < n; k++) begin
            res.value_res = seq_store[k];
            res.last_res  = (k == n - 1);
            res.wrapped   = wrap;
            succ_q.insert(succ_q.size(), res);
        end
    endfunction

    function automatic void absorb_element(logic [VAL_W-1:0] v, logic is_last);
        if (seq_len < MAX_LEN) begin
            seq_store[seq_len] = v;
            seq_len++;
        end
        if (is_last) begin
            queue_successor();
            seq_len = 0;
        end
    endfunction

    // called at a rising edge or at the start; returns at the accepting edge
    task automatic send_element(input logic [VAL_W-1:0] v, input logic is_last);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid      = 1'b1;
        i_item.value = v;
        i_item.last  = is_last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        absorb_element(v, is_last);
        sent_items++;
    endtask

    task automatic send_seq();
        for (int i = 0; i < seq_buf.size(); i++) begin
            send_element(seq_buf[i], i == seq_buf.size() - 1);
        end
        seq_buf.delete();
    endtask

    task automatic test_single_element();
        seq_buf = '{16'h0000};
        send_seq();
        seq_buf = '{16'hFFFF};
        send_seq();
    endtask

    task automatic test_ascending();
        seq_buf = '{16'd1, 16'd2, 16'd3};
        send_seq();
    endtask

    task automatic test_wrap();
        seq_buf = '{16'd3, 16'd2, 16'd1};
        send_seq();
    endtask

    task automatic test_duplicates();
        seq_buf = '{16'd1, 16'd1, 16'd2};
        send_seq();
        seq_buf = '{16'd2, 16'd2, 16'd2};
        send_seq();
        seq_buf = '{16'd1, 16'd2, 16'd2, 16'd1};
        send_seq();
    endtask

    task automatic test_extremes();
        seq_buf = '{16'h0000, 16'hFFFF};
        send_seq();
        seq_buf = '{16'hFFFF, 16'h0000};
        send_seq();
    endtask

    task automatic test_overflow();
        for (int i = 0; i < MAX_LEN + 2; i++) begin
            seq_buf.insert(seq_buf.size(), VAL_W'($urandom_range(0, 7)));
        end
        send_seq();
    endtask

    task automatic test_random_sequences();
        int               len;
        int               kind;
        int               step;
        logic [VAL_W-1:0] v;
        // leave room for the overflow sequence that follows
        while (sent_items < ITEM_TARGET - (MAX_LEN + 2)) begin
            kind = $urandom_range(0, 19);
            if (kind == 0) len = $urandom_range(MAX_LEN - 2, MAX_LEN + 4);
            else if (kind <= 2) len = $urandom_range(9, 40);
            else len = $urandom_range(1, 8);
            kind = $urandom_range(0, 3);
            v = VAL_W'($urandom_range(0, 16'hFFFF));
            for (int i = 0; i < len; i++) begin
                case (kind)
                    0: seq_buf.insert(seq_buf.size(), VAL_W'($urandom_range(0, 3)));
                    1: seq_buf.insert(seq_buf.size(), VAL_W'($urandom_range(0, 16'hFFFF)));
                    2: begin
                        // non-increasing run: always wraps
                        step = (v < 3) ? v : 3;
                        v = v - VAL_W'($urandom_range(0, step));
                        seq_buf.insert(seq_buf.size(), v);
                    end
                    default: seq_buf.insert(seq_buf.size(),
                        VAL_W'($urandom_range(0, 15) << $urandom_range(0, 12)));
                endcase
            end
            send_seq();
        end
    endtask

    // receiver stall pattern, stepping through four modes as stall_cycle advances
    always @(negedge i_clk) begin
        stall_cycle++;
        case ((stall_cycle / 256) % 4)
            0: i_stall = 1'b0;
            1: i_stall = ($urandom_range(0, 3) == 0);
            2: i_stall = $urandom_range(0, 1);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    i_stall = 1'b1;
                end else if ($urandom_range(0, 5) == 0) begin
                    stall_left = $urandom_range(1, 8);
                    i_stall = 1'b1;
                end else begin
                    i_stall = 1'b0;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (succ_q.size() == 0) begin
                $display("%0t: unexpected item, expected none, got %h", $time, o_item);
                error_count++;
            end else begin
                want = succ_q.pop_front();
                if (o_item.value_res !== want.value_res) begin
                    $display("%0t: value_res expected %h got %h",
                             $time, want.value_res, o_item.value_res);
                    error_count++;
                end
                if (o_item.last_res !== want.last_res) begin
                    $display("%0t: last_res expected %b got %b",
                             $time, want.last_res, o_item.last_res);
                    error_count++;
                end
                if (o_item.wrapped !== want.wrapped) begin
                    $display("%0t: wrapped expected %b got %b",
                             $time, want.wrapped, o_item.wrapped);
                    error_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_item      = '0;
        seq_len     = 0;
        sent_items  = 0;
        burst_left  = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_single_element();
        test_ascending();
        test_wrap();
        test_duplicates();
        test_extremes();
        test_random_sequences();
        test_overflow();

        @(negedge i_clk);
        i_valid = 1'b0;
        while (succ_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (succ_q.size() != 0) begin
            $display("%0t: %0d items expected but never seen", $time, succ_q.size());
        end
        if (error_count == 0 && succ_q.size() == 0) begin
            $display("PASS next_permutation_generator");
        end else begin
            $display("FAIL next_permutation_generator");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/npg_pkg.sv
hw/rtl/npg_rom.sv
hw/rtl/npg_ram.sv
hw/rtl/npg_datapath.sv
hw/rtl/next_permutation_generator.sv
test/next_permutation_generator_tb.sv
